// ===== hw/rtl/csvp_pkg.sv =====
// Shared types, codes and helpers of the CSV byte stream parser.
`timescale 1ns / 1ps
`default_nettype none

package csvp_pkg;

    localparam int CNT_W        = 32;
    localparam int NUM_COUNTERS = 4;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Result kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;

    // Row status codes
    localparam logic [2:0] ROW_DATA      = 3'd0;
    localparam logic [2:0] ROW_HEADER    = 3'd1;
    localparam logic [2:0] ROW_BLANK     = 3'd2;
    localparam logic [2:0] ROW_COMMENT   = 3'd3;
    localparam logic [2:0] ROW_MALFORMED = 3'd4;

    // Row counter slots
    localparam logic [1:0] CNT_DATA      = 2'd0;
    localparam logic [1:0] CNT_BLANK     = 2'd1;
    localparam logic [1:0] CNT_SKIPPED   = 2'd2;
    localparam logic [1:0] CNT_MALFORMED = 2'd3;

    // Configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER    = 2'd1;
    localparam logic [7:0]             DELIMITER_RST = 8'd44;
    localparam logic                   HEADER_RST    = 1'b1;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] BOM_0    = 8'hEF;
    localparam logic [7:0] BOM_1    = 8'hBB;
    localparam logic [7:0] BOM_2    = 8'hBF;

    // Source of the byte fed to the field engine
    typedef enum logic [1:0] {
        FEED_BOM0,
        FEED_BOM1,
        FEED_RETURN,
        FEED_BYTE
    } feed_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      latch;
        logic      feed;
        feed_sel_t feed_sel;
        logic      bom_step;
        logic      bom_finish;
        logic      set_return;
        logic      clear_return;
        logic      end_field;
        logic      end_row;
        logic      flush_out;
        logic      reset_file;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic ready;
        logic end_flag;
        logic bom_done;
        logic bom_any;
        logic bom_two;
        logic bom_hit;
        logic held_return;
        logic byte_lf;
        logic byte_cr;
        logic feed_done;
        logic line_exists;
    } status_t;

    // One result transaction
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       field_byte;
        logic [2:0]       row_status;
        logic [CNT_W-1:0] line_number;
        logic [CNT_W-1:0] data_rows;
        logic [CNT_W-1:0] blank_rows;
        logic [CNT_W-1:0] skipped_rows;
        logic [CNT_W-1:0] malformed_rows;
        logic             trim_overflow;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [7:0] bom_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = BOM_0;
            2'd1:    b = BOM_1;
            2'd2:    b = BOM_2;
            default: b = BOM_0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csvp_datapath.sv =====
// Parser state, field engine, row counters and result staging of the CSV parser.
`timescale 1ns / 1ps
`default_nettype none

module csvp_datapath #(
    parameter int HELD_SPACE_MAX = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  var  csvp_pkg::cmd_t   cmd,
    output csvp_pkg::status_t     status,
    input  wire logic [7:0]       delimiter,
    input  wire logic             header_present,
    input  wire logic [7:0]       data_byte,
    input  wire logic             stream_end,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output csvp_pkg::result_t     out_result,
    output logic                  out_last
);

    localparam int CW = $clog2(HELD_SPACE_MAX + 1);
    localparam logic [CW-1:0] HELD_MAX_C = CW'(HELD_SPACE_MAX);

    // Latched input transaction
    logic [7:0] byte_reg, byte_next;
    logic       end_reg, end_next;

    // Parser state
    logic                      in_quote_reg, in_quote_next;
    logic                      quote_pending_reg, quote_pending_next;
    logic                      field_started_reg, field_started_next;
    logic [CW-1:0]             held_count_reg, held_count_next;
    logic [HELD_SPACE_MAX-1:0] held_kinds_reg, held_kinds_next;
    logic                      held_return_reg, held_return_next;
    logic [1:0]                bom_matched_reg, bom_matched_next;
    logic                      bom_done_reg, bom_done_next;
    logic                      line_open_reg, line_open_next;
    logic                      line_is_comment_reg, line_is_comment_next;
    logic                      line_nonblank_reg, line_nonblank_next;
    logic                      delimiter_seen_reg, delimiter_seen_next;
    logic                      field_overflowed_reg, field_overflowed_next;
    logic [csvp_pkg::CNT_W-1:0] line_count_reg, line_count_next;
    logic [csvp_pkg::CNT_W-1:0] cnt_reg  [csvp_pkg::NUM_COUNTERS];
    logic [csvp_pkg::CNT_W-1:0] cnt_next [csvp_pkg::NUM_COUNTERS];

    // Result staging: pending slot and output register
    logic                pend_valid_reg, pend_valid_next;
    csvp_pkg::result_t   pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    csvp_pkg::result_t   out_reg, out_next;
    logic                out_last_reg, out_last_next;

    // Field engine signals
    logic [7:0]        feed_byte;
    logic              is_ws;
    logic              is_tab;
    logic              comment_now;
    logic              act_content;
    logic              act_delim;
    logic              set_open;
    logic              set_qp;
    logic              flush_now;
    logic              out_free;
    logic              emit_valid;
    csvp_pkg::result_t emit_res;
    logic [1:0]        row_sel;
    logic [2:0]        row_code;

    // Select the byte fed to the engine
    always_comb
    begin
        unique case (cmd.feed_sel)
            csvp_pkg::FEED_BOM0:   feed_byte = csvp_pkg::BOM_0;
            csvp_pkg::FEED_BOM1:   feed_byte = csvp_pkg::BOM_1;
            csvp_pkg::FEED_RETURN: feed_byte = csvp_pkg::CH_CR;
            csvp_pkg::FEED_BYTE:   feed_byte = byte_reg;
        endcase
    end

    // Classify the fed byte against quoting and delimiter state
    always_comb
    begin
        is_ws       = (feed_byte == csvp_pkg::CH_SPACE) || (feed_byte == csvp_pkg::CH_TAB);
        is_tab      = (feed_byte == csvp_pkg::CH_TAB);
        comment_now = line_is_comment_reg || (!line_open_reg && feed_byte == csvp_pkg::CH_HASH);
        act_content = 1'b0;
        act_delim   = 1'b0;
        set_open    = 1'b0;
        set_qp      = 1'b0;
        if (!comment_now)
        begin
            priority if (quote_pending_reg && feed_byte == csvp_pkg::CH_QUOTE)
            begin
                act_content = 1'b1;
            end
            else if (in_quote_reg && !quote_pending_reg)
            begin
                if (feed_byte == csvp_pkg::CH_QUOTE)
                    set_qp = 1'b1;
                else
                    act_content = 1'b1;
            end
            else
            begin
                // outside quotes, or a pending quote that closes quoting
                priority if (feed_byte == csvp_pkg::CH_QUOTE)
                    set_open = 1'b1;
                else if (feed_byte == delimiter)
                    act_delim = 1'b1;
                else
                    act_content = 1'b1;
            end
        end
        flush_now = act_content && !is_ws && (held_count_reg != '0);
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Next state of parser, counters and result staging
    always_comb
    begin
        byte_next             = byte_reg;
        end_next              = end_reg;
        in_quote_next         = in_quote_reg;
        quote_pending_next    = quote_pending_reg;
        field_started_next    = field_started_reg;
        held_count_next       = held_count_reg;
        held_kinds_next       = held_kinds_reg;
        held_return_next      = held_return_reg;
        bom_matched_next      = bom_matched_reg;
        bom_done_next         = bom_done_reg;
        line_open_next        = line_open_reg;
        line_is_comment_next  = line_is_comment_reg;
        line_nonblank_next    = line_nonblank_reg;
        delimiter_seen_next   = delimiter_seen_reg;
        field_overflowed_next = field_overflowed_reg;
        line_count_next       = line_count_reg;
        for (int i = 0; i < csvp_pkg::NUM_COUNTERS; i++)
            cnt_next[i] = cnt_reg[i];
        emit_valid = 1'b0;
        emit_res   = '0;
        row_sel    = csvp_pkg::CNT_DATA;
        row_code   = csvp_pkg::ROW_DATA;

        // Capture the accepted input transaction
        if (cmd.latch)
        begin
            byte_next = data_byte;
            end_next  = stream_end;
        end

        // Run one engine step on the fed byte
        if (cmd.feed)
        begin
            if (flush_now)
            begin
                // emit the oldest held whitespace byte
                emit_valid          = 1'b1;
                emit_res.kind       = csvp_pkg::KIND_BYTE;
                emit_res.field_byte = held_kinds_reg[0] ? csvp_pkg::CH_TAB : csvp_pkg::CH_SPACE;
                held_kinds_next     = held_kinds_reg >> 1;
                held_count_next     = held_count_reg - CW'(1);
            end
            else
            begin
                line_open_next = 1'b1;
                if (!is_ws)
                    line_nonblank_next = 1'b1;
                if (!line_open_reg && feed_byte == csvp_pkg::CH_HASH)
                    line_is_comment_next = 1'b1;
                if (!comment_now && quote_pending_reg)
                begin
                    quote_pending_next = 1'b0;
                    if (feed_byte != csvp_pkg::CH_QUOTE)
                        in_quote_next = 1'b0;
                end
                if (set_open)
                    in_quote_next = 1'b1;
                if (set_qp)
                    quote_pending_next = 1'b1;
                if (act_delim)
                begin
                    delimiter_seen_next    = 1'b1;
                    emit_valid             = 1'b1;
                    emit_res.kind          = csvp_pkg::KIND_FIELD_END;
                    emit_res.trim_overflow = field_overflowed_reg;
                    field_started_next     = 1'b0;
                    held_count_next        = '0;
                    held_kinds_next        = '0;
                    field_overflowed_next  = 1'b0;
                end
                if (act_content)
                begin
                    if (is_ws)
                    begin
                        // hold trailing whitespace, drop it once the buffer is full
                        if (field_started_reg)
                        begin
                            if (held_count_reg < HELD_MAX_C)
                            begin
                                for (int i = 0; i < HELD_SPACE_MAX; i++)
                                    if (held_count_reg == CW'(i))
                                        held_kinds_next[i] = is_tab;
                                held_count_next = held_count_reg + CW'(1);
                            end
                            else
                            begin
                                field_overflowed_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        field_started_next  = 1'b1;
                        emit_valid          = 1'b1;
                        emit_res.kind       = csvp_pkg::KIND_BYTE;
                        emit_res.field_byte = feed_byte;
                    end
                end
            end
        end

        // Close the field at line end
        if (cmd.end_field)
        begin
            if (!line_is_comment_reg)
            begin
                emit_valid             = 1'b1;
                emit_res.kind          = csvp_pkg::KIND_FIELD_END;
                emit_res.trim_overflow = field_overflowed_reg;
            end
            field_started_next    = 1'b0;
            held_count_next       = '0;
            held_kinds_next       = '0;
            field_overflowed_next = 1'b0;
        end

        // Classify the row, bump one counter and emit the row end
        if (cmd.end_row)
        begin
            line_count_next = csvp_pkg::sat_inc(line_count_reg);
            priority if (!line_nonblank_reg)
            begin
                row_code = csvp_pkg::ROW_BLANK;
                row_sel  = csvp_pkg::CNT_BLANK;
            end
            else if (line_is_comment_reg)
            begin
                row_code = csvp_pkg::ROW_COMMENT;
                row_sel  = csvp_pkg::CNT_SKIPPED;
            end
            else if (!delimiter_seen_reg)
            begin
                row_code = csvp_pkg::ROW_MALFORMED;
                row_sel  = csvp_pkg::CNT_MALFORMED;
            end
            else if (header_present && line_count_reg == '0)
            begin
                row_code = csvp_pkg::ROW_HEADER;
                row_sel  = csvp_pkg::CNT_SKIPPED;
            end
            else
            begin
                row_code = csvp_pkg::ROW_DATA;
                row_sel  = csvp_pkg::CNT_DATA;
            end
            for (int i = 0; i < csvp_pkg::NUM_COUNTERS; i++)
                if (row_sel == 2'(i))
                    cnt_next[i] = csvp_pkg::sat_inc(cnt_reg[i]);
            emit_valid              = 1'b1;
            emit_res.kind           = csvp_pkg::KIND_ROW_END;
            emit_res.row_status     = row_code;
            emit_res.line_number    = line_count_next;
            emit_res.data_rows      = cnt_next[csvp_pkg::CNT_DATA];
            emit_res.blank_rows     = cnt_next[csvp_pkg::CNT_BLANK];
            emit_res.skipped_rows   = cnt_next[csvp_pkg::CNT_SKIPPED];
            emit_res.malformed_rows = cnt_next[csvp_pkg::CNT_MALFORMED];
            in_quote_next         = 1'b0;
            quote_pending_next    = 1'b0;
            held_return_next      = 1'b0;
            line_open_next        = 1'b0;
            line_is_comment_next  = 1'b0;
            line_nonblank_next    = 1'b0;
            delimiter_seen_next   = 1'b0;
            field_started_next    = 1'b0;
            held_count_next       = '0;
            held_kinds_next       = '0;
            field_overflowed_next = 1'b0;
            bom_done_next         = 1'b1;
            bom_matched_next      = '0;
        end

        // Track the byte order mark prefix
        if (cmd.bom_step)
        begin
            if (bom_matched_reg == 2'd2)
            begin
                bom_done_next    = 1'b1;
                bom_matched_next = '0;
            end
            else
            begin
                bom_matched_next = bom_matched_reg + 2'd1;
            end
        end
        if (cmd.bom_finish)
        begin
            bom_done_next    = 1'b1;
            bom_matched_next = '0;
        end

        if (cmd.set_return)
            held_return_next = 1'b1;
        if (cmd.clear_return)
            held_return_next = 1'b0;

        // Drop all file state after a stream end
        if (cmd.reset_file)
        begin
            in_quote_next         = 1'b0;
            quote_pending_next    = 1'b0;
            field_started_next    = 1'b0;
            held_count_next       = '0;
            held_kinds_next       = '0;
            held_return_next      = 1'b0;
            bom_matched_next      = '0;
            bom_done_next         = 1'b0;
            line_open_next        = 1'b0;
            line_is_comment_next  = 1'b0;
            line_nonblank_next    = 1'b0;
            delimiter_seen_next   = 1'b0;
            field_overflowed_next = 1'b0;
            line_count_next       = '0;
            for (int i = 0; i < csvp_pkg::NUM_COUNTERS; i++)
                cnt_next[i] = '0;
        end
    end

    // Advance results: pending slot feeds the output register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        if (emit_valid)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
        end
        else if (cmd.flush_out && pend_valid_reg)
        begin
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg              <= 1'b0;
            in_quote_reg         <= 1'b0;
            quote_pending_reg    <= 1'b0;
            field_started_reg    <= 1'b0;
            held_count_reg       <= '0;
            held_kinds_reg       <= '0;
            held_return_reg      <= 1'b0;
            bom_matched_reg      <= '0;
            bom_done_reg         <= 1'b0;
            line_open_reg        <= 1'b0;
            line_is_comment_reg  <= 1'b0;
            line_nonblank_reg    <= 1'b0;
            delimiter_seen_reg   <= 1'b0;
            field_overflowed_reg <= 1'b0;
            line_count_reg       <= '0;
            for (int i = 0; i < csvp_pkg::NUM_COUNTERS; i++)
                cnt_reg[i] <= '0;
            pend_valid_reg       <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            end_reg              <= end_next;
            in_quote_reg         <= in_quote_next;
            quote_pending_reg    <= quote_pending_next;
            field_started_reg    <= field_started_next;
            held_count_reg       <= held_count_next;
            held_kinds_reg       <= held_kinds_next;
            held_return_reg      <= held_return_next;
            bom_matched_reg      <= bom_matched_next;
            bom_done_reg         <= bom_done_next;
            line_open_reg        <= line_open_next;
            line_is_comment_reg  <= line_is_comment_next;
            line_nonblank_reg    <= line_nonblank_next;
            delimiter_seen_reg   <= delimiter_seen_next;
            field_overflowed_reg <= field_overflowed_next;
            line_count_reg       <= line_count_next;
            for (int i = 0; i < csvp_pkg::NUM_COUNTERS; i++)
                cnt_reg[i] <= cnt_next[i];
            pend_valid_reg       <= pend_valid_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // Report state to the controller
    always_comb
    begin
        status.ready       = out_free;
        status.end_flag    = end_reg;
        status.bom_done    = bom_done_reg;
        status.bom_any     = (bom_matched_reg != '0);
        status.bom_two     = (bom_matched_reg == 2'd2);
        status.bom_hit     = (byte_reg == csvp_pkg::bom_byte(bom_matched_reg));
        status.held_return = held_return_reg;
        status.byte_lf     = (byte_reg == csvp_pkg::CH_LF);
        status.byte_cr     = (byte_reg == csvp_pkg::CH_CR);
        status.feed_done   = !flush_now;
        status.line_exists = line_open_reg || held_return_reg
                             || (bom_done_reg && line_count_reg == '0);
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign out_last   = out_last_reg;

    // A result that pushes the pending slot out needs a free output register
    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_valid && pend_valid_reg) |-> out_free)
        else $error("pending result pushed into a busy output register");

    a_flush_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.flush_out && pend_valid_reg) |-> out_free)
        else $error("final result pushed into a busy output register");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg <= HELD_MAX_C) && ((held_count_reg == '0) || field_started_reg))
        else $error("held whitespace count out of bound or without field content");

    a_quote_pending: assert property (@(posedge clk) disable iff (!rst_n)
        quote_pending_reg |-> in_quote_reg)
        else $error("quote pending outside quoting");

endmodule

`default_nettype wire

// ===== hw/rtl/csvp_ctrl.sv =====
// Sequencing state machine of the CSV parser: one input transaction at a time.
`timescale 1ns / 1ps
`default_nettype none

module csvp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  var  csvp_pkg::status_t status,
    output csvp_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_REP0,
        S_REP1,
        S_AFTER,
        S_CR,
        S_BYTE,
        S_ENDCHK,
        S_EFIELD,
        S_EROW,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg, in_stall_next;

    // Decode state into commands and the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.ready)
                begin
                    priority if (status.end_flag)
                    begin
                        state_next = (!status.bom_done && status.bom_any) ? S_REP0 : S_ENDCHK;
                    end
                    else if (!status.bom_done)
                    begin
                        priority if (status.bom_hit)
                        begin
                            cmd.bom_step = 1'b1;
                            state_next   = S_DONE;
                        end
                        else if (status.bom_any)
                        begin
                            state_next = S_REP0;
                        end
                        else
                        begin
                            cmd.bom_finish = 1'b1;
                            state_next     = S_AFTER;
                        end
                    end
                    else
                    begin
                        state_next = S_AFTER;
                    end
                end
            end
            S_REP0:
            begin
                if (status.ready)
                begin
                    cmd.feed     = 1'b1;
                    cmd.feed_sel = csvp_pkg::FEED_BOM0;
                    if (status.feed_done)
                    begin
                        if (status.bom_two)
                        begin
                            state_next = S_REP1;
                        end
                        else
                        begin
                            cmd.bom_finish = 1'b1;
                            state_next     = status.end_flag ? S_ENDCHK : S_AFTER;
                        end
                    end
                end
            end
            S_REP1:
            begin
                if (status.ready)
                begin
                    cmd.feed     = 1'b1;
                    cmd.feed_sel = csvp_pkg::FEED_BOM1;
                    if (status.feed_done)
                    begin
                        cmd.bom_finish = 1'b1;
                        state_next     = status.end_flag ? S_ENDCHK : S_AFTER;
                    end
                end
            end
            S_AFTER:
            begin
                if (status.ready)
                begin
                    priority if (status.held_return)
                    begin
                        // a held CR is dropped before LF, otherwise replayed as data
                        cmd.clear_return = 1'b1;
                        state_next       = status.byte_lf ? S_EFIELD : S_CR;
                    end
                    else if (status.byte_lf)
                    begin
                        state_next = S_EFIELD;
                    end
                    else if (status.byte_cr)
                    begin
                        cmd.set_return = 1'b1;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_BYTE;
                    end
                end
            end
            S_CR:
            begin
                if (status.ready)
                begin
                    cmd.feed     = 1'b1;
                    cmd.feed_sel = csvp_pkg::FEED_RETURN;
                    if (status.feed_done)
                        state_next = S_AFTER;
                end
            end
            S_BYTE:
            begin
                if (status.ready)
                begin
                    cmd.feed     = 1'b1;
                    cmd.feed_sel = csvp_pkg::FEED_BYTE;
                    if (status.feed_done)
                        state_next = S_DONE;
                end
            end
            S_ENDCHK:
            begin
                if (status.ready)
                begin
                    cmd.clear_return = 1'b1;
                    state_next       = status.line_exists ? S_EFIELD : S_DONE;
                end
            end
            S_EFIELD:
            begin
                if (status.ready)
                begin
                    cmd.end_field = 1'b1;
                    state_next    = S_EROW;
                end
            end
            S_EROW:
            begin
                if (status.ready)
                begin
                    cmd.end_row = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.ready)
                begin
                    cmd.flush_out  = 1'b1;
                    cmd.reset_file = status.end_flag;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        in_stall_next = (state_next != S_IDLE);
    end

    // Hold state and the registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall = in_stall_reg;

    // An accepted transaction blocks the input until its results are staged
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an accepted transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/csv_byte_stream_parser.sv =====
// Throughput: one input byte at a time; in_stall is raised after each accepted byte and held
// until the controller has fed it through the engine and staged its results, so a new byte
// is not taken before the last one is through. Latency: each result waits in a pending slot
// until the next result or the final flush moves it into the output register.
// Reset: asynchronous active low; clears parser state and counters, delimiter 44,
// header_present 1. An output stall holds the engine while the output register is full.
`timescale 1ns / 1ps
`default_nettype none

module csv_byte_stream_parser #(
    parameter int HELD_SPACE_MAX = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            stream_end,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           kind,
    output logic [7:0]                           field_byte,
    output logic [2:0]                           row_status,
    output logic [31:0]                          line_number,
    output logic [31:0]                          data_rows,
    output logic [31:0]                          blank_rows,
    output logic [31:0]                          skipped_rows,
    output logic [31:0]                          malformed_rows,
    output logic                                 trim_overflow,
    output logic                                 last_of_run,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [csvp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data
);

    logic [7:0]        delimiter_reg, delimiter_next;
    logic              header_present_reg, header_present_next;
    csvp_pkg::cmd_t    cmd;
    csvp_pkg::status_t status;
    csvp_pkg::result_t result;

    // Decode a configuration write transaction; unknown indexes are dropped
    always_comb
    begin
        delimiter_next      = delimiter_reg;
        header_present_next = header_present_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                csvp_pkg::CFG_DELIMITER: delimiter_next      = cfg_data;
                csvp_pkg::CFG_HEADER:    header_present_next = cfg_data[0];
                default:
                begin
                    delimiter_next      = delimiter_reg;
                    header_present_next = header_present_reg;
                end
            endcase
        end
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg      <= csvp_pkg::DELIMITER_RST;
            header_present_reg <= csvp_pkg::HEADER_RST;
        end
        else
        begin
            delimiter_reg      <= delimiter_next;
            header_present_reg <= header_present_next;
        end
    end

    assign cfg_ready = 1'b1;

    csvp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    csvp_datapath #(
        .HELD_SPACE_MAX (HELD_SPACE_MAX)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .delimiter      (delimiter_reg),
        .header_present (header_present_reg),
        .data_byte      (data_byte),
        .stream_end     (stream_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_result     (result),
        .out_last       (last_of_run)
    );

    // Spread the result transaction over its ports
    assign kind           = result.kind;
    assign field_byte     = result.field_byte;
    assign row_status     = result.row_status;
    assign line_number    = result.line_number;
    assign data_rows      = result.data_rows;
    assign blank_rows     = result.blank_rows;
    assign skipped_rows   = result.skipped_rows;
    assign malformed_rows = result.malformed_rows;
    assign trim_overflow  = result.trim_overflow;

endmodule

`default_nettype wire
